// ===== hdl/sat_pkg.sv =====
// shared opcodes, status codes and controller/datapath interface types
`timescale 1ns / 1ps
package sat_pkg;

	localparam int OP_BITS = 4;
	localparam int ST_BITS = 3;

	localparam logic [OP_BITS-1:0] OP_INSERT  = 4'd0;
	localparam logic [OP_BITS-1:0] OP_APPEND  = 4'd1;
	localparam logic [OP_BITS-1:0] OP_POP     = 4'd2;
	localparam logic [OP_BITS-1:0] OP_POP_INS = 4'd3;
	localparam logic [OP_BITS-1:0] OP_REM_AT  = 4'd4;
	localparam logic [OP_BITS-1:0] OP_REM_ENT = 4'd5;
	localparam logic [OP_BITS-1:0] OP_SORT    = 4'd6;
	localparam logic [OP_BITS-1:0] OP_READ    = 4'd7;
	localparam logic [OP_BITS-1:0] OP_CLEAR   = 4'd8;

	localparam logic [ST_BITS-1:0] ST_OK        = 3'd0;
	localparam logic [ST_BITS-1:0] ST_FULL      = 3'd1;
	localparam logic [ST_BITS-1:0] ST_EMPTY     = 3'd2;
	localparam logic [ST_BITS-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [ST_BITS-1:0] ST_BAD_INDEX = 3'd4;

	typedef enum logic [1:0] {
		WS_RDATA,
		WS_TGT,
		WS_TMP
	} wsel_t;

	typedef enum logic [1:0] {
		OS_ZERO,
		OS_TGT,
		OS_TMP
	} osel_t;

	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		wsel_t wr_sel;
		logic  ld_tgt;
		logic  ld_tmp;
		logic  out_ld;
		osel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic key_eq;
		logic key_lt;
		logic id_eq;
		logic gt_tmp;
	} stat_t;

endpackage

// ===== hdl/sat_datapath.sv =====
// table memory, entry registers, key comparators and result key/id registers
`timescale 1ns / 1ps
module sat_datapath #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 16,
	parameter int AW       = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sat_pkg::cmd_t       cmd,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [KEY_BITS-1:0] in_key,
	input  logic [ID_BITS-1:0]  in_id,
	output sat_pkg::stat_t      stat,
	output logic [KEY_BITS-1:0] out_key,
	output logic [ID_BITS-1:0]  out_id
);

	localparam int EW = KEY_BITS + ID_BITS;

	logic [EW-1:0]       mem [DEPTH];
	logic [EW-1:0]       rdata_q;
	logic [EW-1:0]       wdata;
	logic [KEY_BITS-1:0] tgt_key_q;
	logic [ID_BITS-1:0]  tgt_id_q;
	logic [KEY_BITS-1:0] tmp_key_q;
	logic [ID_BITS-1:0]  tmp_id_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [ID_BITS-1:0]  out_id_q;
	logic [KEY_BITS-1:0] rd_key;
	logic [ID_BITS-1:0]  rd_id;

	assign rd_key = rdata_q[EW-1:ID_BITS];
	assign rd_id  = rdata_q[ID_BITS-1:0];

	always_comb begin
		case (cmd.wr_sel)
			sat_pkg::WS_TGT: wdata = {tgt_key_q, tgt_id_q};
			sat_pkg::WS_TMP: wdata = {tmp_key_q, tmp_id_q};
			default:         wdata = rdata_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_key_q <= '0;
			tgt_id_q  <= '0;
			tmp_key_q <= '0;
			tmp_id_q  <= '0;
			out_key_q <= '0;
			out_id_q  <= '0;
		end else begin
			if (cmd.ld_tgt) begin
				tgt_key_q <= in_key;
				tgt_id_q  <= in_id;
			end
			if (cmd.ld_tmp) begin
				tmp_key_q <= rd_key;
				tmp_id_q  <= rd_id;
			end
			if (cmd.out_ld) begin
				case (cmd.out_sel)
					sat_pkg::OS_TGT: begin
						out_key_q <= tgt_key_q;
						out_id_q  <= tgt_id_q;
					end
					sat_pkg::OS_TMP: begin
						out_key_q <= tmp_key_q;
						out_id_q  <= tmp_id_q;
					end
					default: begin
						out_key_q <= '0;
						out_id_q  <= '0;
					end
				endcase
			end
		end
	end

	assign stat.key_eq = (rd_key == tgt_key_q);
	assign stat.key_lt = ($signed(rd_key) < $signed(tgt_key_q));
	assign stat.id_eq  = (rd_id == tgt_id_q);
	assign stat.gt_tmp = ($signed(rd_key) > $signed(tmp_key_q));

	assign out_key = out_key_q;
	assign out_id  = out_id_q;

endmodule

// ===== hdl/sat_ctrl.sv =====
// operation sequencer: bisection, shifts, scans, sort and result handshake
`timescale 1ns / 1ps
module sat_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sat_pkg::OP_BITS-1:0]  in_op,
	input  logic [AW-1:0]                in_pos,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [sat_pkg::ST_BITS-1:0]  res_status,
	output logic [AW-1:0]                res_position,
	output logic [CW-1:0]                res_count,
	output sat_pkg::cmd_t                cmd,
	output logic [AW-1:0]                rd_addr,
	output logic [AW-1:0]                wr_addr,
	input  sat_pkg::stat_t               stat
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_POP_W, S_PI_W, S_RA_W, S_RD_W,
		S_BIS, S_BIS_W, S_INS, S_INS_W, S_SHD, S_SHD_W,
		S_FB, S_FB_W, S_FE_W, S_DN, S_DN_W, S_UP, S_UP_W,
		S_SO, S_SLD, S_SIN, S_SCMP, S_FIN
	} state_t;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE      = CW'(1);

	state_t                        state_q;
	logic [sat_pkg::OP_BITS-1:0]   op_q;
	logic [CW-1:0]                 pos_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic [CW-1:0]                 mid_q;
	logic [CW-1:0]                 i_q;
	logic [CW-1:0]                 j_q;
	logic [CW-1:0]                 idx_q;
	logic [sat_pkg::ST_BITS-1:0]   st_q;
	logic [AW-1:0]                 rpos_q;
	sat_pkg::osel_t                rsel_q;
	logic                          valid_q;
	logic [sat_pkg::ST_BITS-1:0]   out_st_q;
	logic [AW-1:0]                 out_pos_q;
	logic [CW-1:0]                 out_cnt_q;
	logic [CW:0]                   sum;
	logic [CW-1:0]                 mid_c;
	logic                          full;
	logic                          empty;
	logic                          pos_bad;
	logic                          hit;
	logic                          out_free;
	logic [CW-1:0]                 rd_c;
	logic [CW-1:0]                 wr_c;

	assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c    = sum[CW:1];
	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign pos_bad  = (pos_q >= cnt_q);
	assign hit      = stat.key_eq && stat.id_eq;
	assign out_free = !valid_q || res_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.wr_sel  = sat_pkg::WS_RDATA;
		cmd.out_sel = rsel_q;
		rd_c        = '0;
		wr_c        = '0;
		case (state_q)
			S_IDLE: cmd.ld_tgt = in_valid;
			S_DISP: begin
				case (op_q)
					sat_pkg::OP_APPEND: begin
						cmd.wr_en  = !full;
						cmd.wr_sel = sat_pkg::WS_TGT;
						wr_c       = cnt_q;
					end
					sat_pkg::OP_POP, sat_pkg::OP_POP_INS: begin
						cmd.rd_en = !empty;
						rd_c      = cnt_q - ONE;
					end
					sat_pkg::OP_REM_AT, sat_pkg::OP_READ: begin
						cmd.rd_en = !pos_bad;
						rd_c      = pos_q;
					end
					default: cmd.rd_en = 1'b0;
				endcase
			end
			S_POP_W, S_PI_W, S_RA_W, S_RD_W, S_SLD: cmd.ld_tmp = 1'b1;
			S_BIS: begin
				cmd.rd_en = (lo_q < hi_q);
				rd_c      = mid_c;
			end
			S_INS: begin
				if (i_q > idx_q) begin
					cmd.rd_en = 1'b1;
					rd_c      = i_q - ONE;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sat_pkg::WS_TGT;
					wr_c       = idx_q;
				end
			end
			S_INS_W, S_SHD_W: begin
				cmd.wr_en = 1'b1;
				wr_c      = i_q;
			end
			S_SHD: begin
				cmd.rd_en = ((i_q + ONE) < cnt_q);
				rd_c      = i_q + ONE;
			end
			S_FB: begin
				if (lo_q < hi_q) begin
					cmd.rd_en = 1'b1;
					rd_c      = mid_c;
				end else begin
					cmd.rd_en = (lo_q < cnt_q);
					rd_c      = lo_q;
				end
			end
			S_FB_W, S_DN_W, S_UP_W, S_FE_W: cmd.ld_tmp = hit;
			S_DN: begin
				cmd.rd_en = (i_q != '0);
				rd_c      = i_q - ONE;
			end
			S_UP: begin
				cmd.rd_en = (j_q < cnt_q);
				rd_c      = j_q;
			end
			S_SO: begin
				cmd.rd_en = (i_q < cnt_q);
				rd_c      = i_q;
			end
			S_SIN: begin
				if (j_q != '0) begin
					cmd.rd_en = 1'b1;
					rd_c      = j_q - ONE;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sat_pkg::WS_TMP;
					wr_c       = j_q;
				end
			end
			S_SCMP: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = stat.gt_tmp ? sat_pkg::WS_RDATA : sat_pkg::WS_TMP;
				wr_c       = j_q;
			end
			S_FIN: cmd.out_ld = out_free;
			default: cmd.ld_tgt = 1'b0;
		endcase
	end

	assign rd_addr = rd_c[AW-1:0];
	assign wr_addr = wr_c[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			pos_q     <= '0;
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			idx_q     <= '0;
			st_q      <= sat_pkg::ST_OK;
			rpos_q    <= '0;
			rsel_q    <= sat_pkg::OS_ZERO;
			valid_q   <= 1'b0;
			out_st_q  <= sat_pkg::ST_OK;
			out_pos_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_q && res_ready && (state_q != S_FIN)) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_op;
						pos_q   <= CW'(in_pos);
						st_q    <= sat_pkg::ST_OK;
						rpos_q  <= '0;
						rsel_q  <= sat_pkg::OS_ZERO;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					lo_q    <= '0;
					hi_q    <= cnt_q;
					case (op_q)
						sat_pkg::OP_INSERT: begin
							if (full) st_q <= sat_pkg::ST_FULL;
							else state_q <= S_BIS;
						end
						sat_pkg::OP_APPEND: begin
							if (full) begin
								st_q <= sat_pkg::ST_FULL;
							end else begin
								cnt_q  <= cnt_q + ONE;
								rpos_q <= cnt_q[AW-1:0];
								rsel_q <= sat_pkg::OS_TGT;
							end
						end
						sat_pkg::OP_POP, sat_pkg::OP_POP_INS: begin
							if (empty) begin
								st_q <= sat_pkg::ST_EMPTY;
							end else begin
								cnt_q   <= cnt_q - ONE;
								hi_q    <= cnt_q - ONE;
								state_q <= (op_q == sat_pkg::OP_POP) ? S_POP_W : S_PI_W;
							end
						end
						sat_pkg::OP_REM_AT, sat_pkg::OP_READ: begin
							if (pos_bad) begin
								st_q <= sat_pkg::ST_BAD_INDEX;
							end else begin
								idx_q   <= pos_q;
								i_q     <= pos_q;
								state_q <= (op_q == sat_pkg::OP_READ) ? S_RD_W : S_RA_W;
							end
						end
						sat_pkg::OP_REM_ENT: state_q <= S_FB;
						sat_pkg::OP_SORT: begin
							i_q     <= ONE;
							state_q <= S_SO;
						end
						sat_pkg::OP_CLEAR: cnt_q <= '0;
						default: st_q <= sat_pkg::ST_OK;
					endcase
				end
				S_POP_W, S_RD_W: begin
					rsel_q  <= sat_pkg::OS_TMP;
					rpos_q  <= (state_q == S_POP_W) ? cnt_q[AW-1:0] : pos_q[AW-1:0];
					state_q <= S_FIN;
				end
				S_PI_W: state_q <= S_BIS;
				S_RA_W: state_q <= S_SHD;
				S_BIS: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c;
						state_q <= S_BIS_W;
					end else begin
						idx_q   <= lo_q;
						i_q     <= cnt_q;
						state_q <= S_INS;
					end
				end
				S_BIS_W: begin
					if (stat.key_eq) begin
						idx_q   <= mid_q;
						i_q     <= cnt_q;
						state_q <= S_INS;
					end else begin
						if (stat.key_lt) lo_q <= mid_q + ONE;
						else hi_q <= mid_q;
						state_q <= S_BIS;
					end
				end
				S_INS: begin
					if (i_q > idx_q) begin
						state_q <= S_INS_W;
					end else begin
						cnt_q   <= cnt_q + ONE;
						rpos_q  <= idx_q[AW-1:0];
						rsel_q  <= (op_q == sat_pkg::OP_POP_INS) ? sat_pkg::OS_TMP
							: sat_pkg::OS_TGT;
						state_q <= S_FIN;
					end
				end
				S_INS_W: begin
					i_q     <= i_q - ONE;
					state_q <= S_INS;
				end
				S_SHD: begin
					if ((i_q + ONE) < cnt_q) begin
						state_q <= S_SHD_W;
					end else begin
						cnt_q   <= cnt_q - ONE;
						rpos_q  <= idx_q[AW-1:0];
						rsel_q  <= sat_pkg::OS_TMP;
						state_q <= S_FIN;
					end
				end
				S_SHD_W: begin
					i_q     <= i_q + ONE;
					state_q <= S_SHD;
				end
				S_FB: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c;
						state_q <= S_FB_W;
					end else if (lo_q < cnt_q) begin
						state_q <= S_FE_W;
					end else begin
						st_q    <= sat_pkg::ST_NOT_FOUND;
						state_q <= S_FIN;
					end
				end
				S_FB_W: begin
					if (stat.key_eq) begin
						i_q     <= mid_q;
						idx_q   <= mid_q;
						j_q     <= mid_q + ONE;
						state_q <= stat.id_eq ? S_SHD : S_DN;
					end else begin
						if (stat.key_lt) lo_q <= mid_q + ONE;
						else hi_q <= mid_q;
						state_q <= S_FB;
					end
				end
				S_FE_W: begin
					if (hit) begin
						i_q     <= lo_q;
						idx_q   <= lo_q;
						state_q <= S_SHD;
					end else begin
						st_q    <= sat_pkg::ST_NOT_FOUND;
						state_q <= S_FIN;
					end
				end
				S_DN: begin
					if (i_q != '0) begin
						i_q     <= i_q - ONE;
						state_q <= S_DN_W;
					end else begin
						state_q <= S_UP;
					end
				end
				S_DN_W: begin
					if (!stat.key_eq) begin
						state_q <= S_UP;
					end else if (stat.id_eq) begin
						idx_q   <= i_q;
						state_q <= S_SHD;
					end else begin
						state_q <= S_DN;
					end
				end
				S_UP: begin
					if (j_q < cnt_q) begin
						state_q <= S_UP_W;
					end else begin
						st_q    <= sat_pkg::ST_NOT_FOUND;
						state_q <= S_FIN;
					end
				end
				S_UP_W: begin
					if (hit) begin
						i_q     <= j_q;
						idx_q   <= j_q;
						state_q <= S_SHD;
					end else if (!stat.key_eq) begin
						st_q    <= sat_pkg::ST_NOT_FOUND;
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + ONE;
						state_q <= S_UP;
					end
				end
				S_SO: begin
					state_q <= (i_q < cnt_q) ? S_SLD : S_FIN;
				end
				S_SLD: begin
					j_q     <= i_q;
					state_q <= S_SIN;
				end
				S_SIN: begin
					if (j_q != '0) begin
						state_q <= S_SCMP;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_SO;
					end
				end
				S_SCMP: begin
					if (stat.gt_tmp) begin
						j_q     <= j_q - ONE;
						state_q <= S_SIN;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_SO;
					end
				end
				S_FIN: begin
					if (out_free) begin
						valid_q   <= 1'b1;
						out_st_q  <= st_q;
						out_pos_q <= rpos_q;
						out_cnt_q <= cnt_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid    = valid_q;
	assign res_status   = out_st_q;
	assign res_position = out_pos_q;
	assign res_count    = out_cnt_q;

endmodule

// ===== hdl/sorted_array_table_core.sv =====
// top level of the sorted (key, id) table
`timescale 1ns / 1ps
// Sorted table of up to DEPTH (key, id) entries held in one single-port-write,
// registered-read memory; one request is worked at a time and gives one result.
// A request passes through accept, dispatch and result, plus: a read wait for
// pop and read; insert adds bisection steps, a search end unless a midpoint key
// is equal, a shift up of (count - position) cells and the entry write, and pop
// then insert adds its read wait; remove at adds a read wait, a shift down of
// (count - position - 1) cells and an end step; remove entry adds bisection
// steps, a search end or an end cell check, a scan of an equal-key run plus a
// step where a scan runs off the table, and the same shift down as remove at;
// sort adds a start step, then a pass per element after the first, a step per
// element passed and one where it stops short of index 0. Append, clear and
// unknown codes take only accept, dispatch and result. A result that cannot
// enter the output register holds the block until it can; a new request is
// taken once the previous result has been placed in the output register.
module sorted_array_table_core #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 16,
	localparam int AW      = $clog2(DEPTH),
	localparam int CW      = $clog2(DEPTH + 1),
	localparam int IN_W    = sat_pkg::OP_BITS + KEY_BITS + ID_BITS + AW,
	localparam int IN_PADW = (IN_W + 7) / 8 * 8,
	localparam int OUT_W   = sat_pkg::ST_BITS + KEY_BITS + ID_BITS + AW + CW,
	localparam int OUT_PADW = (OUT_W + 7) / 8 * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// operation, entry_key, entry_id, position
	input  logic [IN_PADW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// status, out_key, out_id, out_position, entry_count
	output logic [OUT_PADW-1:0] m_tdata
);

	localparam int KEY_LO = sat_pkg::OP_BITS;
	localparam int ID_LO  = KEY_LO + KEY_BITS;
	localparam int POS_LO = ID_LO + ID_BITS;

	sat_pkg::cmd_t               cmd;
	sat_pkg::stat_t              stat;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic [sat_pkg::ST_BITS-1:0] res_status;
	logic [AW-1:0]               res_position;
	logic [CW-1:0]               res_count;
	logic [KEY_BITS-1:0]         out_key;
	logic [ID_BITS-1:0]          out_id;

	sat_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tdata[sat_pkg::OP_BITS-1:0]),
		.in_pos       (s_tdata[POS_LO +: AW]),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_status   (res_status),
		.res_position (res_position),
		.res_count    (res_count),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.stat         (stat)
	);

	sat_datapath #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS),
		.ID_BITS  (ID_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.in_key  (s_tdata[KEY_LO +: KEY_BITS]),
		.in_id   (s_tdata[ID_LO +: ID_BITS]),
		.stat    (stat),
		.out_key (out_key),
		.out_id  (out_id)
	);

	assign m_tdata = OUT_PADW'({res_count, res_position, out_id, out_key, res_status});

endmodule

// ===== sim/sat_checker.sv =====
// checker for the sorted table core: watches both streams, predicts and compares
`timescale 1ns / 1ps
module sat_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] key;
		logic [15:0] id;
		logic [5:0]  pos;
		logic [6:0]  cnt;
	} answer_t;

	logic signed [31:0] tab_key [64];
	logic [15:0] tab_id [64];
	int tab_cnt;
	answer_t answers [$];

	assign pending = answers.size();

	function automatic int find_slot(logic signed [31:0] k);
		int lo, hi, mid;
		lo = 0;
		hi = tab_cnt;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (tab_key[mid] == k)
				return mid;
			if (tab_key[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic void place(int at, logic signed [31:0] k, logic [15:0] d);
		for (int i = tab_cnt; i > at; i--) begin
			tab_key[i] = tab_key[i-1];
			tab_id[i] = tab_id[i-1];
		end
		tab_key[at] = k;
		tab_id[at] = d;
		tab_cnt++;
	endfunction

	function automatic void drop(int at);
		for (int i = at; i + 1 < tab_cnt; i++) begin
			tab_key[i] = tab_key[i+1];
			tab_id[i] = tab_id[i+1];
		end
		tab_cnt--;
	endfunction

	function automatic int locate(logic signed [31:0] k, logic [15:0] d);
		int lo, hi, mid;
		lo = 0;
		hi = tab_cnt;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (tab_key[mid] == k) begin
				for (int i = mid; i >= 0 && tab_key[i] == k; i--)
					if (tab_id[i] == d) return i;
				for (int j = mid + 1; j < tab_cnt && tab_key[j] == k; j++)
					if (tab_id[j] == d) return j;
				return -1;
			end
			if (tab_key[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < tab_cnt && tab_key[lo] == k && tab_id[lo] == d)
			return lo;
		return -1;
	endfunction

	function automatic answer_t apply_request(logic [63:0] req);
		answer_t a;
		logic [3:0] op;
		logic signed [31:0] k, tk;
		logic [15:0] d, td;
		int p, at, j;
		op = req[3:0];
		k = req[35:4];
		d = req[51:36];
		p = int'({26'd0, req[57:52]});
		a = '0;
		case (op)
			sat_pkg::OP_INSERT, sat_pkg::OP_APPEND: begin
				if (tab_cnt >= 64)
					a.status = sat_pkg::ST_FULL;
				else begin
					at = (op == sat_pkg::OP_INSERT) ? find_slot(k) : tab_cnt;
					place(at, k, d);
					a.key = k; a.id = d; a.pos = 6'(at);
				end
			end
			sat_pkg::OP_POP, sat_pkg::OP_POP_INS: begin
				if (tab_cnt == 0)
					a.status = sat_pkg::ST_EMPTY;
				else begin
					tab_cnt--;
					a.key = tab_key[tab_cnt]; a.id = tab_id[tab_cnt]; a.pos = 6'(tab_cnt);
					if (op == sat_pkg::OP_POP_INS) begin
						at = find_slot(k);
						place(at, k, d);
						a.pos = 6'(at);
					end
				end
			end
			sat_pkg::OP_REM_AT, sat_pkg::OP_READ: begin
				if (p >= tab_cnt)
					a.status = sat_pkg::ST_BAD_INDEX;
				else begin
					a.key = tab_key[p]; a.id = tab_id[p]; a.pos = 6'(p);
					if (op == sat_pkg::OP_REM_AT) drop(p);
				end
			end
			sat_pkg::OP_REM_ENT: begin
				at = locate(k, d);
				if (at < 0)
					a.status = sat_pkg::ST_NOT_FOUND;
				else begin
					a.key = tab_key[at]; a.id = tab_id[at]; a.pos = 6'(at);
					drop(at);
				end
			end
			sat_pkg::OP_SORT: begin
				for (int i = 1; i < tab_cnt; i++) begin
					tk = tab_key[i];
					td = tab_id[i];
					j = i;
					while (j > 0 && tab_key[j-1] > tk) begin
						tab_key[j] = tab_key[j-1];
						tab_id[j] = tab_id[j-1];
						j--;
					end
					tab_key[j] = tk;
					tab_id[j] = td;
				end
			end
			sat_pkg::OP_CLEAR: tab_cnt = 0;
			default: ;
		endcase
		a.cnt = 7'(tab_cnt);
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		tab_cnt = 0;
	end

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[2:0], m_tdata[34:3], m_tdata[50:35], m_tdata[56:51],
					m_tdata[63:57]};
				if (answers.size() == 0)
					report_mismatch("unexpected result", 32'd0, 32'd0);
				else begin
					want = answers.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.key != want.key) report_mismatch("key", got.key, want.key);
					if (got.id != want.id)
						report_mismatch("id", 32'(got.id), 32'(want.id));
					if (got.pos != want.pos)
						report_mismatch("position", 32'(got.pos), 32'(want.pos));
					if (got.cnt != want.cnt)
						report_mismatch("count", 32'(got.cnt), 32'(want.cnt));
				end
			end
			if (s_tvalid && s_tready)
				answers.push_back(apply_request(s_tdata));
		end
	end
endmodule

// ===== sim/tb_sorted_array_table_core.sv =====
// testbench top for the sorted table core: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module tb_sorted_array_table_core;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	int fail_count, pending;
	int cycles = 0;
	int hold_off = 0;
	bit stim_done = 0;
	logic signed [31:0] used_key [$];
	logic [15:0] used_id [$];

	always #5 clk = ~clk;

	sorted_array_table_core dut (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	sat_checker chk (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// small key pool makes equal-key runs common
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return $signed($urandom_range(0, 7)) - 4;
		if (r < 6 && used_key.size() > 0) return used_key[$urandom_range(0, used_key.size() - 1)];
		if (r == 6) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	task automatic send(logic [3:0] op, logic signed [31:0] k, logic [15:0] d, logic [5:0] p);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tdata <= {6'd0, p, d, k, op};
		s_tvalid <= 1;
		if (op == sat_pkg::OP_INSERT || op == sat_pkg::OP_APPEND
				|| op == sat_pkg::OP_POP_INS) begin
			used_key.push_back(k);
			used_id.push_back(d);
			if (used_key.size() > 200) begin
				void'(used_key.pop_front());
				void'(used_id.pop_front());
			end
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random();
		int r, i;
		logic [3:0] op;
		logic signed [31:0] k;
		logic [15:0] d;
		r = $urandom_range(0, 99);
		k = pick_key();
		d = 16'($urandom_range(0, 7));
		if ($urandom_range(0, 5) == 0) d = 16'($urandom);
		if (r < 30) op = sat_pkg::OP_INSERT;
		else if (r < 36) op = sat_pkg::OP_APPEND;
		else if (r < 46) op = sat_pkg::OP_POP;
		else if (r < 54) op = sat_pkg::OP_POP_INS;
		else if (r < 64) op = sat_pkg::OP_REM_AT;
		else if (r < 78) op = sat_pkg::OP_REM_ENT;
		else if (r < 82) op = sat_pkg::OP_SORT;
		else if (r < 94) op = sat_pkg::OP_READ;
		else if (r < 96) op = sat_pkg::OP_CLEAR;
		else op = 4'($urandom_range(9, 15));
		if (op == sat_pkg::OP_REM_ENT && used_key.size() > 0 && $urandom_range(0, 3) != 0) begin
			i = $urandom_range(0, used_key.size() - 1);
			k = used_key[i];
			d = used_id[i];
		end
		send(op, k, d, 6'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else if (cycles == 3000) begin
			hold_off <= 300;
			m_tready <= 0;
		end else if (cycles > 20000 && cycles < 23000)
			m_tready <= 1;
		else
			m_tready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed part
		send(sat_pkg::OP_POP, 0, 0, 0);
		send(sat_pkg::OP_POP_INS, 5, 1, 0);
		send(sat_pkg::OP_READ, 0, 0, 0);
		send(sat_pkg::OP_REM_AT, 0, 0, 63);
		send(sat_pkg::OP_REM_ENT, 3, 3, 0);
		send(sat_pkg::OP_INSERT, 32'sh7fffffff, 16'hffff, 0);
		send(sat_pkg::OP_INSERT, 32'sh80000000, 16'h0000, 0);
		send(sat_pkg::OP_INSERT, 7, 1, 0);
		send(sat_pkg::OP_INSERT, 7, 2, 0);
		send(sat_pkg::OP_INSERT, 7, 3, 0);
		send(sat_pkg::OP_APPEND, -9, 4, 0);
		send(sat_pkg::OP_READ, 0, 0, 63);
		send(sat_pkg::OP_SORT, 0, 0, 0);
		send(sat_pkg::OP_READ, 0, 0, 0);
		send(sat_pkg::OP_REM_ENT, 7, 3, 0);
		send(sat_pkg::OP_REM_ENT, 7, 9, 0);
		send(sat_pkg::OP_POP_INS, 7, 5, 0);
		send(sat_pkg::OP_REM_AT, 0, 0, 1);
		send(sat_pkg::OP_POP, 0, 0, 0);
		send(4'd15, 32'shffffffff, 16'hffff, 6'h3f);
		send(sat_pkg::OP_CLEAR, 0, 0, 0);
		// fill to full, then overflow both ways
		repeat (64) send(sat_pkg::OP_INSERT, pick_key(), 16'($urandom_range(0, 3)), 0);
		send(sat_pkg::OP_INSERT, 1, 1, 0);
		send(sat_pkg::OP_APPEND, 1, 1, 0);
		send(sat_pkg::OP_READ, 0, 0, 63);
		send(sat_pkg::OP_REM_AT, 0, 0, 63);
		send(sat_pkg::OP_CLEAR, 0, 0, 0);
		repeat (1750) send_random();
		s_tvalid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
